[src/lrupr_pkg.sv]
package lrupr_pkg;

    localparam int FRAMES      = 8;
    localparam int PAGE_BITS   = 20;
    localparam int FRAME_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CFG_W       = 4;
    localparam int CNT_W       = 32;
    localparam int PAGE_IN_W   = 20;
    localparam int FRAME_OUT_W = 3;
    localparam int IN_W        = 24;
    localparam int OUT_W       = 64;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE
    } t_state;

    // result of the ripple search, passed from cell to cell
    typedef struct packed {
        logic                 hit_found;
        logic [FRAME_W-1:0]   hit_idx;
        logic [FRAME_W-1:0]   hit_rank;
        logic                 free_found;
        logic [FRAME_W-1:0]   free_idx;
        logic                 lru_found;
        logic [FRAME_W-1:0]   lru_idx;
        logic [FRAME_W-1:0]   lru_rank;
        logic [PAGE_BITS-1:0] lru_page;
    } t_chain;

    // update broadcast to every cell
    typedef struct packed {
        logic                 en;
        logic                 clear;
        logic [FRAME_W-1:0]   frame;
        logic [FRAME_W-1:0]   old_rank;
        logic                 age_all;
        logic                 write;
        logic [PAGE_BITS-1:0] page;
    } t_upd;

endpackage

[src/lru_page_replacement.sv]
// an accepted input beat passes through the search step (S_SEARCH) and the update step
//   (S_UPDATE), then appears as a registered result beat on the master side; the search
//   passes along the frame cells, then the rank update follows, one item in search or update at a time
// a result beat that is not taken holds the block in its update step until it is taken
// reset (i_rst_n low, synchronous): all frames empty, ranks and miss count zero,
//   frames_in_use back to 8
module lru_page_replacement (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: frames_in_use
    input  logic                          i_cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0]   i_cfg_wdata,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lrupr_pkg::IN_W-1:0]    s_axis_tdata,  // [19:0] page_number, rest zero
    input  logic                          s_axis_tlast,  // last_in_string
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lrupr_pkg::OUT_W-1:0]   m_axis_tdata   // [0] hit, [3:1] frame_index,
                                                         // [4] evicted_valid,
                                                         // [24:5] evicted_page,
                                                         // [56:25] miss_count, rest zero
);

    localparam int FR = lrupr_pkg::FRAMES;
    localparam int FW = lrupr_pkg::FRAME_W;
    localparam int PB = lrupr_pkg::PAGE_BITS;

    lrupr_pkg::t_state r_state, n_state;

    // configuration register and effective frame limit
    logic [lrupr_pkg::CFG_W-1:0] r_cfg;
    logic [lrupr_pkg::CFG_W-1:0] w_limit;
    logic [FR-1:0]               w_in_limit;

    // captured request
    logic [PB-1:0]               r_page;
    logic                        r_last;

    // registered search result
    lrupr_pkg::t_chain           r_dec;

    // cell chain
    lrupr_pkg::t_chain           w_chain [FR+1];
    logic [FR-1:0]               w_match;
    lrupr_pkg::t_upd             w_upd;

    // miss counter and result register
    logic [lrupr_pkg::CNT_W-1:0] r_miss;
    logic [lrupr_pkg::CNT_W-1:0] w_miss_next;
    logic                        r_out_valid;
    logic [lrupr_pkg::OUT_W-1:0] r_out_data;

    // handshake and step controls
    logic w_in_beat;
    logic w_out_beat;
    logic w_capture;
    logic w_latch_dec;
    logic w_commit;

    // decision fields
    logic          w_hit;
    logic          w_evict;
    logic [FW-1:0] w_frame;

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_out_beat = r_out_valid && m_axis_tready;

    // register value zero acts as one, values above the frame count act as the frame count
    always_comb begin
        if (r_cfg == '0) begin
            w_limit = lrupr_pkg::CFG_W'(1);
        end else if (int'(r_cfg) > FR) begin
            w_limit = lrupr_pkg::CFG_W'(FR);
        end else begin
            w_limit = r_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lrupr_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrupr_pkg::S_IDLE: begin
                if (w_in_beat) n_state = lrupr_pkg::S_SEARCH;
            end
            lrupr_pkg::S_SEARCH: begin
                n_state = lrupr_pkg::S_UPDATE;
            end
            lrupr_pkg::S_UPDATE: begin
                if (!r_out_valid || m_axis_tready) n_state = lrupr_pkg::S_IDLE;
            end
            default: n_state = lrupr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_latch_dec   = 1'b0;
        w_commit      = 1'b0;
        case (r_state)
            lrupr_pkg::S_IDLE:   s_axis_tready = 1'b1;
            lrupr_pkg::S_SEARCH: w_latch_dec   = 1'b1;
            lrupr_pkg::S_UPDATE: w_commit      = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign w_capture = w_in_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrupr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture; pages compare on their low PAGE_BITS bits
    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_page <= PB'(s_axis_tdata[lrupr_pkg::PAGE_IN_W-1:0]);
            r_last <= s_axis_tlast;
        end
    end

    // ---------------- frame cells ----------------
    // the search ripples from frame 0 upward: first hit, lowest free frame inside
    // the limit, oldest valid frame inside the limit
    assign w_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < FR; g++) begin : g_cell
            assign w_in_limit[g] = (g < int'(w_limit));

            lrupr_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_idx      (FW'(g)),
                .i_in_limit (w_in_limit[g]),
                .i_page     (r_page),
                .i_chain    (w_chain[g]),
                .o_chain    (w_chain[g+1]),
                .i_upd      (w_upd),
                .o_match    (w_match[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_latch_dec) begin
            r_dec <= w_chain[FR];
        end
    end

    // ---------------- decision and update broadcast ----------------
    assign w_hit   = r_dec.hit_found;
    assign w_evict = !r_dec.hit_found && !r_dec.free_found;

    always_comb begin
        if (r_dec.hit_found) begin
            w_frame = r_dec.hit_idx;
        end else if (r_dec.free_found) begin
            w_frame = r_dec.free_idx;
        end else begin
            w_frame = r_dec.lru_idx;
        end
    end

    // a hit ages frames younger than the hit frame, a fill ages every valid frame,
    // an eviction ages frames younger than the victim; a last item clears every frame
    always_comb begin
        w_upd.en       = w_commit;
        w_upd.clear    = r_last;
        w_upd.frame    = w_frame;
        w_upd.old_rank = r_dec.hit_found ? r_dec.hit_rank : r_dec.lru_rank;
        w_upd.age_all  = !r_dec.hit_found && r_dec.free_found;
        w_upd.write    = !r_dec.hit_found;
        w_upd.page     = r_page;
    end

    // saturating miss count
    always_comb begin
        if (w_hit || (r_miss == '1)) begin
            w_miss_next = r_miss;
        end else begin
            w_miss_next = r_miss + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss <= '0;
        end else if (w_commit) begin
            r_miss <= r_last ? '0 : w_miss_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (w_out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data <= {
                7'd0,
                w_miss_next,
                w_evict ? lrupr_pkg::PAGE_IN_W'(r_dec.lru_page) : '0,
                w_evict,
                lrupr_pkg::FRAME_OUT_W'(w_frame),
                w_hit
            };
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    // a page is only written on a miss, so at most one frame can match
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrupr_pkg::S_SEARCH) |-> $onehot0(w_match))
        else $error("more than one frame holds the same page");

    // an accepted beat always starts a search in the next cycle
    a_accept_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> (r_state == lrupr_pkg::S_SEARCH))
        else $error("accepted beat did not start a search");

    // each committed update produces a result beat
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> m_axis_tvalid)
        else $error("update committed without a result beat");

    // no new input while a search or update is in progress
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lrupr_pkg::S_IDLE) |-> !s_axis_tready)
        else $error("input ready while an item is in progress");

endmodule

[src/lrupr_cell.sv]
module lrupr_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [lrupr_pkg::FRAME_W-1:0]        i_idx,
    input  logic                                 i_in_limit,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]      i_page,
    input  lrupr_pkg::t_chain                    i_chain,
    output lrupr_pkg::t_chain                    o_chain,
    input  lrupr_pkg::t_upd                      i_upd,
    output logic                                 o_match
);

    logic [lrupr_pkg::PAGE_BITS-1:0] r_page;
    logic                            r_valid;
    logic [lrupr_pkg::FRAME_W-1:0]   r_rank;
    logic                            w_sel;

    assign o_match = r_valid && (r_page == i_page);
    assign w_sel   = (i_upd.frame == i_idx);

    always_comb begin
        o_chain = i_chain;
        if (o_match && !i_chain.hit_found) begin
            o_chain.hit_found = 1'b1;
            o_chain.hit_idx   = i_idx;
            o_chain.hit_rank  = r_rank;
        end
        if (!r_valid && i_in_limit && !i_chain.free_found) begin
            o_chain.free_found = 1'b1;
            o_chain.free_idx   = i_idx;
        end
        if (r_valid && i_in_limit && (!i_chain.lru_found || r_rank > i_chain.lru_rank)) begin
            o_chain.lru_found = 1'b1;
            o_chain.lru_idx   = i_idx;
            o_chain.lru_rank  = r_rank;
            o_chain.lru_page  = r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.en) begin
            if (i_upd.clear) begin
                r_valid <= 1'b0;
                r_rank  <= '0;
            end else if (w_sel) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (r_valid && (i_upd.age_all || r_rank < i_upd.old_rank)) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en && w_sel && i_upd.write) begin
            r_page <= i_upd.page;
        end
    end

endmodule
